/* src/tournament_branch_predictor_core_assert.svh */
// Assertion macros used by the tournament predictor controller.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_CORE_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tbp_pkg.sv */
// Package with types, constants and helper functions of the tournament predictor.
`timescale 1ns / 1ps
package tbp_pkg;

    // Table geometry. LOCAL_PHT_ENTRIES must be a power of two.
    localparam int LOCAL_HIST_BITS   = 10;
    localparam int LOCAL_PHT_ENTRIES = 1024;
    localparam int GLOBAL_HIST_BITS  = 12;

    localparam int LHT_DEPTH  = 1024;
    localparam int GTAB_DEPTH = 4096;
    localparam int LHT_IDX_W  = $clog2(LHT_DEPTH);
    localparam int GIDX_W     = $clog2(GTAB_DEPTH);
    localparam int LPHT_IDX_W = $clog2(LOCAL_PHT_ENTRIES);
    localparam int LHIST_W    = LOCAL_HIST_BITS;
    localparam int GHIST_W    = GLOBAL_HIST_BITS;

    // The clearing pass covers the deepest table.
    localparam int CLR_DEPTH = (LOCAL_PHT_ENTRIES > GTAB_DEPTH) ? LOCAL_PHT_ENTRIES
                                                                : GTAB_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    localparam int ADDR_W = 64;
    localparam int FOLD_LO_W = 10;
    localparam int FOLD_HI_W = 12;

    // Two-bit saturating counter values.
    localparam logic [1:0] CTR_MIN        = 2'd0;
    localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX        = 2'd3;

    typedef logic [1:0] t_ctr;

    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_SHIFT   = 2'd1,
        OP_TRAIN   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [63:0] branch_address;
        logic        outcome_taken;
        logic [11:0] saved_global_index;
        logic [9:0]  saved_local_index;
        logic        saved_global_vote;
        logic        saved_local_vote;
    } t_in_item;

    typedef struct packed {
        logic        predicted_taken;
        logic [11:0] global_index;
        logic [9:0]  local_index;
        logic        global_vote;
        logic        local_vote;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             lookup;
        logic             shift_wr;
        logic             train_wr;
        logic             out_load;
        logic             clr_wr;
        logic [CLR_W-1:0] clr_idx;
    } t_dp_cmd;

    // XOR fold of the address into 10-bit chunks; the top chunk is 4 bits wide.
    function automatic logic [FOLD_LO_W-1:0] fold10(input logic [ADDR_W-1:0] a);
        logic [FOLD_LO_W-1:0] r;
        r = '0;
        for (int s = 0; s < ADDR_W; s += FOLD_LO_W) begin
            r ^= FOLD_LO_W'(a >> s);
        end
        return r;
    endfunction

    // XOR fold of the address into 12-bit chunks; the top chunk is 4 bits wide.
    function automatic logic [FOLD_HI_W-1:0] fold12(input logic [ADDR_W-1:0] a);
        logic [FOLD_HI_W-1:0] r;
        r = '0;
        for (int s = 0; s < ADDR_W; s += FOLD_HI_W) begin
            r ^= FOLD_HI_W'(a >> s);
        end
        return r;
    endfunction

    // Saturating step of a two-bit counter.
    function automatic t_ctr sat_move(input t_ctr c, input logic up);
        t_ctr r;
        if (up) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

/* src/tbp_datapath.sv */
// Datapath of the tournament predictor: history and counter tables and result register.
`timescale 1ns / 1ps
module tbp_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbp_pkg::t_in_item  i_in_data,
    input  tbp_pkg::t_dp_cmd   i_cmd,
    output tbp_pkg::t_out_item o_out_data
);
    import tbp_pkg::*;

    // Table storage.
    logic [LHIST_W-1:0] lht_mem [LHT_DEPTH];
    t_ctr               lct_mem [LOCAL_PHT_ENTRIES];
    t_ctr               gct_mem [GTAB_DEPTH];
    t_ctr               cct_mem [GTAB_DEPTH];

    logic [GHIST_W-1:0]    r_ghist;
    logic [LHT_IDX_W-1:0]  r_lh_idx;
    logic [LHIST_W-1:0]    r_lht_q;
    logic [GIDX_W-1:0]     r_gi;
    logic [LPHT_IDX_W-1:0] r_li;
    t_ctr                  r_lct_q;
    t_ctr                  r_gct_q;
    t_ctr                  r_cct_q;
    logic                  r_taken;
    logic                  r_saved_gv;
    logic                  r_saved_lv;
    t_out_item             r_out;

    logic [LHT_IDX_W-1:0]  lh_idx;
    logic [GIDX_W-1:0]     gi_sel;
    logic [LPHT_IDX_W-1:0] li_hist;
    logic [LPHT_IDX_W-1:0] li_sel;
    logic                  lct_rd;
    logic                  lv;
    logic                  gv;
    logic                  pred;

    // Index selection: predict hashes the address, train uses the saved indices.
    always_comb begin
        lh_idx  = LHT_IDX_W'(fold10(i_in_data.branch_address));
        if (i_in_data.opcode == OP_TRAIN) begin
            gi_sel = i_in_data.saved_global_index;
        end else begin
            gi_sel = GIDX_W'(r_ghist) ^ GIDX_W'(fold12(i_in_data.branch_address));
        end
        // Power-of-two table: the modulo is the low bits of the history.
        li_hist = LPHT_IDX_W'(r_lht_q);
        li_sel  = i_cmd.lookup ? li_hist : LPHT_IDX_W'(i_in_data.saved_local_index);
        lct_rd  = i_cmd.accept | i_cmd.lookup;
    end

    // Operand registers and table reads taken with the beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lh_idx   <= lh_idx;
            r_lht_q    <= lht_mem[lh_idx];
            r_gi       <= gi_sel;
            r_gct_q    <= gct_mem[gi_sel];
            r_cct_q    <= cct_mem[gi_sel];
            r_taken    <= i_in_data.outcome_taken;
            r_saved_gv <= i_in_data.saved_global_vote;
            r_saved_lv <= i_in_data.saved_local_vote;
        end
        if (lct_rd) begin
            r_li    <= li_sel;
            r_lct_q <= lct_mem[li_sel];
        end
    end

    // Global history register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist <= '0;
        end else if (i_cmd.shift_wr) begin
            r_ghist <= GHIST_W'({r_ghist, r_taken});
        end
    end

    // Local history table writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            lht_mem[LHT_IDX_W'(i_cmd.clr_idx)] <= '0;
        end else if (i_cmd.shift_wr) begin
            lht_mem[r_lh_idx] <= LHIST_W'({r_lht_q, r_taken});
        end
    end

    // Local counter table writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            lct_mem[LPHT_IDX_W'(i_cmd.clr_idx)] <= CTR_WEAK_TAKEN;
        end else if (i_cmd.train_wr) begin
            lct_mem[r_li] <= sat_move(r_lct_q, r_taken);
        end
    end

    // Global counter table writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            gct_mem[GIDX_W'(i_cmd.clr_idx)] <= CTR_WEAK_TAKEN;
        end else if (i_cmd.train_wr) begin
            gct_mem[r_gi] <= sat_move(r_gct_q, r_taken);
        end
    end

    // Chooser table writes; the chooser learns only when the votes disagreed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            cct_mem[GIDX_W'(i_cmd.clr_idx)] <= CTR_WEAK_TAKEN;
        end else if (i_cmd.train_wr && (r_saved_gv != r_saved_lv)) begin
            cct_mem[r_gi] <= sat_move(r_cct_q, r_saved_gv == r_taken);
        end
    end

    // Final choice between the component votes.
    always_comb begin
        lv   = r_lct_q[1];
        gv   = r_gct_q[1];
        pred = lv;
        if (lv != gv) begin
            pred = r_cct_q[1] ? gv : lv;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.predicted_taken <= pred;
            r_out.global_index    <= r_gi;
            r_out.local_index     <= 10'(r_li);
            r_out.global_vote     <= gv;
            r_out.local_vote      <= lv;
        end
    end

    assign o_out_data = r_out;

endmodule

/* src/tbp_ctrl.sv */
// Controller of the tournament predictor: clearing pass, operation sequencing, output valid.
`timescale 1ns / 1ps
`include "tournament_branch_predictor_core_assert.svh"
module tbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tbp_pkg::t_opcode  i_opcode,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tbp_pkg::t_dp_cmd  o_cmd
);
    import tbp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_RESOLVE,
        S_UPDATE
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_opcode          r_op;
    t_opcode          n_op;
    logic [CLR_W-1:0] r_clr_idx;
    logic [CLR_W-1:0] n_clr_idx;
    logic             r_out_valid;
    logic             n_out_valid;
    t_dp_cmd          cmd;

    // Commands and next state.
    always_comb begin
        cmd         = '0;
        cmd.clr_idx = r_clr_idx;
        n_state     = r_state;
        n_op        = r_op;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                n_clr_idx  = r_clr_idx + 1'b1;
                if (r_clr_idx == CLR_W'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_op       = i_opcode;
                    case (i_opcode)
                        OP_PREDICT:         n_state = S_LOOKUP;
                        OP_SHIFT, OP_TRAIN: n_state = S_UPDATE;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                n_state    = S_RESOLVE;
            end
            S_RESOLVE: begin
                // Wait here until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_UPDATE: begin
                if (r_op == OP_SHIFT) begin
                    cmd.shift_wr = 1'b1;
                end else begin
                    cmd.train_wr = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_op        <= OP_NONE;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A result is loaded only into a free or draining result register.
    `TBP_ASSERT_NOW(a_load_free, i_clk, i_rst_n, cmd.out_load,
        !r_out_valid || i_out_ready, "result overwritten before it was taken")
    // A predict beat is followed by the local counter lookup.
    `TBP_ASSERT_NEXT(a_predict_lookup, i_clk, i_rst_n,
        cmd.accept && (i_opcode == OP_PREDICT), cmd.lookup, "predict lookup skipped")
    // Table writes never coincide with taking a new beat.
    `TBP_ASSERT_NOW(a_write_not_ready, i_clk, i_rst_n,
        cmd.shift_wr || cmd.train_wr || cmd.clr_wr, !o_in_ready,
        "table write while accepting a beat")

endmodule

/* src/tournament_branch_predictor_core.sv */
// Top level of the tournament branch predictor (local history, gshare and chooser).
`timescale 1ns / 1ps
// After reset the block runs a clearing pass over the deepest table that sets histories
// to zero and counters to weakly taken; it takes no beat in that time. Then it works on
// one beat at a time. A predict reads the history table with the beat, then the local
// counter table in the lookup state, and loads the result register in the resolve state.
// Shift and train read the tables with the beat, then write back in the update state.
// An unknown opcode is accepted and dropped. The result register lets the next beat be
// accepted while a prediction still waits to be taken. A later predict that finds the
// result register still full holds in its resolve state until that result is taken,
// and input stays stalled meanwhile.
module tournament_branch_predictor_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tbp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tbp_pkg::t_out_item o_out_data
);
    import tbp_pkg::*;

    t_dp_cmd cmd;

    // Sequencing.
    tbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_data.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Tables and result.
    tbp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_out_data (o_out_data)
    );

endmodule
